// File: hdl/dtt_pkg.sv
// dtt_pkg: types, codes and constants of the deadline timer table.
// Used by hdl/deadline_timer_table.sv. No dependencies.
package dtt_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int RCW         = $clog2(MAX_RESULTS + 1);
	localparam logic [31:0] WINDOW_RESET = 32'd3600000; // one hour in ms
	localparam logic [47:0] TIME_MAX     = {48{1'b1}};

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_CANCEL  = 3'd1,
		CMD_REFRESH = 3'd2,
		CMD_RESET   = 3'd3,
		CMD_EXPIRE  = 3'd4,
		CMD_QUERY   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INACTIVE = 2'd1,
		ST_FULL     = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_ADJ,
		S_MIN,
		S_DUE,
		S_CNT,
		S_SEL,
		S_EMIT,
		S_FIN
	} state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  slot;
		logic [31:0] period_ms;
		logic        recurring;
		logic        restart;
		logic [47:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_out;
		logic        new_earliest;
		logic [47:0] time_to_next;
		logic        any_active;
		logic        last;
	} res_t;

	// deadline + period, saturating at the top of the time range
	function automatic logic [47:0] sat_add(input logic [47:0] t, input logic [31:0] p);
		logic [48:0] s;
		s = {1'b0, t} + {17'b0, p};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

endpackage

// File: hdl/deadline_timer_table.sv
// deadline_timer_table: timer slot table with add, cancel, refresh, reset,
// expire and query commands. Depends on hdl/dtt_pkg.sv.
//
// A request is taken when start is high and busy is low; busy stays high until
// the command has finished. Results appear on result for one cycle each with
// result_valid high and cannot be held off. The earliest-deadline and due
// scans visit one slot per cycle; add finds its free slot combinationally.
// Cancel and refresh end after the execute step; add and query scan the table
// (add on a full table does not); a reset that changes a slot adjusts it, then scans.
// Expire scans for due slots, then once per reported slot, at most 16 reported,
// one result per reported slot. The rollover window register is written through
// cfg_valid/cfg_data at any time the block is idle.
module deadline_timer_table #(
	parameter int SLOTS = dtt_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  dtt_pkg::req_t request,
	output logic          result_valid,
	output dtt_pkg::res_t result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SW = (IW > 4) ? IW : 4;
	localparam int CW = $clog2(SLOTS + 1);

	dtt_pkg::state_t state_q, state_d;

	logic [SLOTS-1:0] act_q, recf_q, due_q;
	logic [47:0]      prev_q;
	logic             tickle_q;
	logic [31:0]      window_q;
	logic             roll_q, any_fin_q, bv_q, place_q, res_valid_q;
	logic [IW-1:0]    scan_q, best_q, tgt_q;
	logic [dtt_pkg::RCW-1:0] cnt_q, nrep_q;

	dtt_pkg::req_t    req_q;
	dtt_pkg::res_t    res_q;
	logic [1:0]       status_q;
	logic [47:0]      dl_q  [SLOTS];
	logic [31:0]      per_q [SLOTS];
	logic [47:0]      best_dl_q, start_q;

	logic [SW-1:0]    s_ext, tgt_ext, best_ext;
	logic [IW-1:0]    sidx, free_idx, rd_idx;
	logic             ok_slot, vs, free_found, any_act, scan_last, cand, better, emit_last;
	logic [47:0]      rd_dl;
	logic [31:0]      rd_per, oldp;
	logic [CW-1:0]    pc;

	assign s_ext    = SW'(req_q.slot);
	assign sidx     = s_ext[IW-1:0];
	assign tgt_ext  = SW'(tgt_q);
	assign best_ext = SW'(best_q);
	assign ok_slot  = 32'(req_q.slot) < 32'(SLOTS);
	assign vs       = ok_slot && act_q[sidx];
	assign any_act  = |act_q;
	assign scan_last = scan_q == IW'(SLOTS - 1);
	assign pc       = CW'($countones(due_q));
	assign emit_last = (cnt_q + 1'b1) == nrep_q;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!act_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// outputs and the single table read port
	always_comb begin
		busy      = state_q != dtt_pkg::S_IDLE;
		cfg_ready = 1'b1;
		case (state_q)
			dtt_pkg::S_EXEC: rd_idx = (req_q.command == dtt_pkg::CMD_ADD) ? free_idx : sidx;
			dtt_pkg::S_ADJ:  rd_idx = sidx;
			dtt_pkg::S_EMIT: rd_idx = best_q;
			default:         rd_idx = scan_q;
		endcase
	end

	assign rd_dl  = dl_q[rd_idx];
	assign rd_per = per_q[rd_idx];
	assign oldp   = ok_slot ? rd_per : 32'd0;
	assign cand   = (state_q == dtt_pkg::S_SEL) ? due_q[rd_idx] : act_q[rd_idx];
	assign better = cand && (!bv_q || rd_dl < best_dl_q);

	assign result_valid = res_valid_q;
	assign result       = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			dtt_pkg::S_IDLE: if (start) state_d = dtt_pkg::S_EXEC;
			dtt_pkg::S_EXEC: begin
				case (req_q.command)
					dtt_pkg::CMD_ADD:
						state_d = free_found ? dtt_pkg::S_MIN : dtt_pkg::S_FIN;
					dtt_pkg::CMD_RESET:
						state_d = ((req_q.period_ms == oldp && !req_q.restart) || !vs)
							? dtt_pkg::S_FIN : dtt_pkg::S_ADJ;
					dtt_pkg::CMD_EXPIRE:
						state_d = any_act ? dtt_pkg::S_DUE : dtt_pkg::S_FIN;
					dtt_pkg::CMD_QUERY: state_d = dtt_pkg::S_MIN;
					default:            state_d = dtt_pkg::S_FIN;
				endcase
			end
			dtt_pkg::S_ADJ:  state_d = dtt_pkg::S_MIN;
			dtt_pkg::S_MIN:  if (scan_last) state_d = dtt_pkg::S_FIN;
			dtt_pkg::S_DUE:  if (scan_last) state_d = dtt_pkg::S_CNT;
			dtt_pkg::S_CNT:  state_d = (pc == '0) ? dtt_pkg::S_FIN : dtt_pkg::S_SEL;
			dtt_pkg::S_SEL:  if (scan_last) state_d = dtt_pkg::S_EMIT;
			dtt_pkg::S_EMIT: state_d = emit_last ? dtt_pkg::S_IDLE : dtt_pkg::S_SEL;
			dtt_pkg::S_FIN:  state_d = dtt_pkg::S_IDLE;
			default:         state_d = dtt_pkg::S_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtt_pkg::S_IDLE;
			act_q       <= '0;
			recf_q      <= '0;
			due_q       <= '0;
			prev_q      <= '0;
			tickle_q    <= 1'b0;
			window_q    <= dtt_pkg::WINDOW_RESET;
			roll_q      <= 1'b0;
			any_fin_q   <= 1'b0;
			bv_q        <= 1'b0;
			place_q     <= 1'b0;
			res_valid_q <= 1'b0;
			scan_q      <= '0;
			cnt_q       <= '0;
			nrep_q      <= '0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= 1'b0;
			if (cfg_valid) window_q <= cfg_data;
			case (state_q)
				dtt_pkg::S_EXEC: begin
					scan_q  <= '0;
					bv_q    <= 1'b0;
					place_q <= 1'b0;
					case (req_q.command)
						dtt_pkg::CMD_ADD: if (free_found) begin
							act_q[free_idx]  <= 1'b1;
							recf_q[free_idx] <= req_q.recurring;
							place_q          <= 1'b1;
						end
						dtt_pkg::CMD_CANCEL: if (vs) act_q[sidx] <= 1'b0;
						dtt_pkg::CMD_EXPIRE: if (any_act) begin
							roll_q <= ({1'b0, req_q.now_ms} + {17'b0, window_q})
								< {1'b0, prev_q};
							prev_q <= req_q.now_ms;
						end
						default: ;
					endcase
				end
				dtt_pkg::S_ADJ: place_q <= 1'b1;
				dtt_pkg::S_MIN, dtt_pkg::S_SEL: begin
					if (better) bv_q <= 1'b1;
					scan_q <= scan_q + 1'b1;
				end
				dtt_pkg::S_DUE: begin
					due_q[scan_q] <= act_q[scan_q] && (roll_q || rd_dl <= req_q.now_ms);
					scan_q <= scan_q + 1'b1;
				end
				dtt_pkg::S_CNT: begin
					nrep_q <= (32'(pc) > 32'(dtt_pkg::MAX_RESULTS))
						? dtt_pkg::RCW'(dtt_pkg::MAX_RESULTS) : dtt_pkg::RCW'(pc);
					// due slots beyond the report limit stay active
					any_fin_q <= (32'(pc) > 32'(dtt_pkg::MAX_RESULTS))
						|| (|(act_q & ~(due_q & ~recf_q)));
					cnt_q  <= '0;
					scan_q <= '0;
					bv_q   <= 1'b0;
				end
				dtt_pkg::S_EMIT: begin
					due_q[best_q] <= 1'b0;
					if (!recf_q[best_q]) act_q[best_q] <= 1'b0;
					cnt_q       <= cnt_q + 1'b1;
					scan_q      <= '0;
					bv_q        <= 1'b0;
					res_valid_q <= 1'b1;
				end
				dtt_pkg::S_FIN: begin
					res_valid_q <= 1'b1;
					if (place_q && bv_q && best_q == tgt_q && !tickle_q) tickle_q <= 1'b1;
					if (req_q.command == dtt_pkg::CMD_QUERY && bv_q) tickle_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload: request, slot table, scan results
	always_ff @(posedge clk) begin
		case (state_q)
			dtt_pkg::S_IDLE: if (start) req_q <= request;
			dtt_pkg::S_EXEC: begin
				status_q <= dtt_pkg::ST_OK;
				tgt_q    <= sidx;
				case (req_q.command)
					dtt_pkg::CMD_ADD: begin
						if (!free_found) status_q <= dtt_pkg::ST_FULL;
						else begin
							per_q[free_idx] <= req_q.period_ms;
							dl_q[free_idx]  <= dtt_pkg::sat_add(req_q.now_ms, req_q.period_ms);
							tgt_q           <= free_idx;
						end
					end
					dtt_pkg::CMD_CANCEL: if (!vs) status_q <= dtt_pkg::ST_INACTIVE;
					dtt_pkg::CMD_REFRESH: begin
						if (!vs) status_q <= dtt_pkg::ST_INACTIVE;
						else dl_q[sidx] <= dtt_pkg::sat_add(req_q.now_ms, rd_per);
					end
					dtt_pkg::CMD_RESET: begin
						if (!(req_q.period_ms == oldp && !req_q.restart)) begin
							if (!vs) status_q <= dtt_pkg::ST_INACTIVE;
						end
						if (req_q.restart) start_q <= req_q.now_ms;
						else start_q <= (rd_dl >= 48'(oldp)) ? rd_dl - 48'(oldp) : 48'd0;
					end
					dtt_pkg::CMD_EXPIRE: if (!any_act) status_q <= dtt_pkg::ST_NONE;
					default: ;
				endcase
			end
			dtt_pkg::S_ADJ: begin
				per_q[sidx] <= req_q.period_ms;
				dl_q[sidx]  <= dtt_pkg::sat_add(start_q, req_q.period_ms);
			end
			dtt_pkg::S_MIN, dtt_pkg::S_SEL: if (better) begin
				best_q    <= scan_q;
				best_dl_q <= rd_dl;
			end
			dtt_pkg::S_CNT: if (pc == '0) status_q <= dtt_pkg::ST_NONE;
			dtt_pkg::S_EMIT: begin
				res_q.status       <= dtt_pkg::ST_OK;
				res_q.slot_out     <= best_ext[3:0];
				res_q.new_earliest <= 1'b0;
				res_q.time_to_next <= '0;
				res_q.any_active   <= any_fin_q;
				res_q.last         <= emit_last;
				if (recf_q[best_q]) dl_q[best_q] <= dtt_pkg::sat_add(req_q.now_ms, rd_per);
			end
			dtt_pkg::S_FIN: begin
				res_q.status       <= status_q;
				res_q.slot_out     <= (req_q.command == dtt_pkg::CMD_ADD && place_q)
					? tgt_ext[3:0] : 4'd0;
				res_q.new_earliest <= place_q && bv_q && best_q == tgt_q && !tickle_q;
				if (req_q.command != dtt_pkg::CMD_QUERY) res_q.time_to_next <= '0;
				else if (!bv_q) res_q.time_to_next <= dtt_pkg::TIME_MAX;
				else res_q.time_to_next <= (req_q.now_ms >= best_dl_q)
					? 48'd0 : best_dl_q - req_q.now_ms;
				res_q.any_active   <= any_act;
				res_q.last         <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: tb/deadline_timer_table_tb.sv
// deadline_timer_table_tb: self-checking bench for the deadline timer table.
// Depends on hdl/dtt_pkg.sv and hdl/deadline_timer_table.sv.
module deadline_timer_table_tb;

	localparam int NSLOT = 16;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	dtt_pkg::req_t request;
	logic          result_valid;
	dtt_pkg::res_t result;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [31:0]   cfg_data;

	deadline_timer_table DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.result_valid(result_valid), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// shadow of the timer table
	logic        tm_act [NSLOT];
	logic        tm_rec [NSLOT];
	logic [31:0] tm_per [NSLOT];
	logic [47:0] tm_dl  [NSLOT];
	logic [47:0] last_expire_time;
	logic        tickled;
	logic [31:0] window_ms;

	dtt_pkg::req_t pending_reqs[$];
	dtt_pkg::res_t expected_results[$];
	int   pushed, accepted, errors, gap;
	bit   took;
	longint unsigned cycles;
	logic [47:0] tnow;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [47:0] clamp_sum(logic [47:0] t, logic [31:0] p);
		logic [48:0] s;
		s = {1'b0, t} + {17'b0, p};
		return s[48] ? dtt_pkg::TIME_MAX : s[47:0];
	endfunction

	function automatic bit ahead(int a, int b);
		if (tm_dl[a] != tm_dl[b])
			return tm_dl[a] < tm_dl[b];
		return a < b;
	endfunction

	function automatic int first_deadline();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++)
			if (tm_act[i] && (best < 0 || ahead(i, best)))
				best = i;
		return best;
	endfunction

	function automatic bit table_busy();
		for (int i = 0; i < NSLOT; i++)
			if (tm_act[i])
				return 1;
		return 0;
	endfunction

	function automatic bit mark_front(int i);
		bit front;
		front = (first_deadline() == i) && !tickled;
		if (front)
			tickled = 1;
		return front;
	endfunction

	// Apply one request to the shadow table and queue the results it yields.
	task automatic apply_request(dtt_pkg::req_t rq);
		dtt_pkg::res_t outs[$];
		dtt_pkg::res_t r;
		int f, b, e;
		bit roll, due[NSLOT];
		logic [47:0] st;
		logic [48:0] lim;
		r = '0;
		r.last = 1;
		case (rq.command)
			dtt_pkg::CMD_ADD: begin
				f = -1;
				for (int i = 0; i < NSLOT && f < 0; i++)
					if (!tm_act[i])
						f = i;
				if (f < 0) begin
					r.status = dtt_pkg::ST_FULL;
				end else begin
					tm_act[f] = 1;
					tm_rec[f] = rq.recurring;
					tm_per[f] = rq.period_ms;
					tm_dl[f] = clamp_sum(rq.now_ms, rq.period_ms);
					r.slot_out = 4'(f);
					r.new_earliest = mark_front(f);
				end
				outs = {outs, r};
			end
			dtt_pkg::CMD_CANCEL, dtt_pkg::CMD_REFRESH: begin
				if (!tm_act[rq.slot])
					r.status = dtt_pkg::ST_INACTIVE;
				else if (rq.command == dtt_pkg::CMD_CANCEL)
					tm_act[rq.slot] = 0;
				else
					tm_dl[rq.slot] = clamp_sum(rq.now_ms, tm_per[rq.slot]);
				outs = {outs, r};
			end
			dtt_pkg::CMD_RESET: begin
				if (rq.period_ms == tm_per[rq.slot] && !rq.restart) begin
					// same period, keep start: no change at all
				end else if (!tm_act[rq.slot]) begin
					r.status = dtt_pkg::ST_INACTIVE;
				end else begin
					if (rq.restart)
						st = rq.now_ms;
					else if (tm_dl[rq.slot] >= {16'b0, tm_per[rq.slot]})
						st = tm_dl[rq.slot] - {16'b0, tm_per[rq.slot]};
					else
						st = '0;
					tm_per[rq.slot] = rq.period_ms;
					tm_dl[rq.slot] = clamp_sum(st, rq.period_ms);
					r.new_earliest = mark_front(int'(rq.slot));
				end
				outs = {outs, r};
			end
			dtt_pkg::CMD_EXPIRE: begin
				if (!table_busy()) begin
					r.status = dtt_pkg::ST_NONE;
					outs = {outs, r};
				end else begin
					lim = {1'b0, rq.now_ms} + {17'b0, window_ms};
					roll = lim < {1'b0, last_expire_time};
					last_expire_time = rq.now_ms;
					for (int i = 0; i < NSLOT; i++)
						due[i] = tm_act[i] && (roll || tm_dl[i] <= rq.now_ms);
					while (outs.size() < dtt_pkg::MAX_RESULTS) begin
						b = -1;
						for (int i = 0; i < NSLOT; i++)
							if (due[i] && (b < 0 || ahead(i, b)))
								b = i;
						if (b < 0)
							break;
						due[b] = 0;
						r = '0;
						r.slot_out = 4'(b);
						outs = {outs, r};
						if (tm_rec[b])
							tm_dl[b] = clamp_sum(rq.now_ms, tm_per[b]);
						else
							tm_act[b] = 0;
					end
					if (outs.size() == 0) begin
						r = '0;
						r.status = dtt_pkg::ST_NONE;
						outs = {outs, r};
					end
					outs[outs.size() - 1].last = 1;
				end
			end
			dtt_pkg::CMD_QUERY: begin
				e = first_deadline();
				if (e < 0) begin
					r.time_to_next = dtt_pkg::TIME_MAX;
				end else begin
					tickled = 0;
					r.time_to_next = rq.now_ms >= tm_dl[e] ? 48'd0 : tm_dl[e] - rq.now_ms;
				end
				outs = {outs, r};
			end
			default: outs = {outs, r};
		endcase
		foreach (outs[k]) begin
			outs[k].any_active = table_busy();
			expected_results = {expected_results, outs[k]};
		end
	endtask

	// driver: one nonblocking write of start per falling edge
	always @(negedge clk) begin
		logic nxt;
		if (arst_n) begin
			nxt = start;
			if (start && took) begin
				nxt = 0;
				took = 0;
			end
			if (!nxt) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_reqs.size() > 0) begin
					request <= pending_reqs.pop_front();
					nxt = 1;
					gap = $urandom_range(0, 7);
				end
			end
			start <= nxt;
		end
	end

	// monitor: checks results, then records an accepted request
	always @(posedge clk) begin
		dtt_pkg::res_t w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[deadline_timer_table] ERROR");
			$finish;
		end else begin
			if (arst_n && result_valid) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result %p", result);
					errors++;
				end else begin
					w = expected_results.pop_front();
					if (result.status !== w.status) begin
						$error("status exp %0d got %0d", w.status, result.status);
						errors++;
					end
					if (result.slot_out !== w.slot_out) begin
						$error("slot_out exp %0d got %0d", w.slot_out, result.slot_out);
						errors++;
					end
					if (result.new_earliest !== w.new_earliest) begin
						$error("new_earliest exp %0d got %0d", w.new_earliest,
							result.new_earliest);
						errors++;
					end
					if (result.time_to_next !== w.time_to_next) begin
						$error("time_to_next exp %0h got %0h", w.time_to_next,
							result.time_to_next);
						errors++;
					end
					if (result.any_active !== w.any_active) begin
						$error("any_active exp %0d got %0d", w.any_active, result.any_active);
						errors++;
					end
					if (result.last !== w.last) begin
						$error("last exp %0d got %0d", w.last, result.last);
						errors++;
					end
				end
			end
			if (arst_n && start && !busy) begin
				took = 1;
				accepted++;
				apply_request(request);
			end
		end
	end

	function automatic dtt_pkg::req_t mk(logic [2:0] c, logic [3:0] s, logic [31:0] p,
		logic rc, logic fn, logic [47:0] t);
		dtt_pkg::req_t q;
		q.command = c;
		q.slot = s;
		q.period_ms = p;
		q.recurring = rc;
		q.restart = fn;
		q.now_ms = t;
		return q;
	endfunction

	task automatic send(dtt_pkg::req_t q);
		pending_reqs = {pending_reqs, q};
		pushed++;
	endtask

	// everything sent has been answered and the block is idle again
	task automatic drain();
		do @(negedge clk);
		while (accepted != pushed || expected_results.size() != 0 || busy || start);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_window(logic [31:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk);
		while (!cfg_ready);
		window_ms = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] rand_period();
		case ($urandom_range(0, 9))
			0: return 32'hFFFF_FFFF;
			1: return $urandom;
			2: return 0;
			default: return $urandom_range(1, 120);
		endcase
	endfunction

	function automatic dtt_pkg::req_t rand_request();
		int pick;
		logic [2:0] c;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 19))
			0: tnow = {16'($urandom_range(0, 65535)), 32'($urandom)};
			1: tnow = tnow - 48'($urandom_range(0, 5000000));
			2: tnow = dtt_pkg::TIME_MAX - 48'($urandom_range(0, 200));
			default: tnow = tnow + 48'($urandom_range(0, 40));
		endcase
		if (pick < 25) c = dtt_pkg::CMD_ADD;
		else if (pick < 50) c = dtt_pkg::CMD_EXPIRE;
		else if (pick < 63) c = dtt_pkg::CMD_QUERY;
		else if (pick < 73) c = dtt_pkg::CMD_CANCEL;
		else if (pick < 83) c = dtt_pkg::CMD_REFRESH;
		else if (pick < 98) c = dtt_pkg::CMD_RESET;
		else c = 3'($urandom_range(6, 7));
		return mk(c, 4'($urandom_range(0, 15)), rand_period(), 1'($urandom),
			1'($urandom), tnow);
	endfunction

	initial begin
		logic [31:0] windows [4];
		arst_n = 0;
		start = 0;
		request = '0;
		cfg_valid = 0;
		cfg_data = '0;
		took = 0;
		gap = 0;
		for (int i = 0; i < NSLOT; i++) begin
			tm_act[i] = 0;
			tm_rec[i] = 0;
			tm_per[i] = '0;
			tm_dl[i] = '0;
		end
		last_expire_time = '0;
		tickled = 0;
		window_ms = dtt_pkg::WINDOW_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, fill it up (every period gets written), then
		// each command and the saturation, tie and rollover corners
		send(mk(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 48'd5));
		send(mk(dtt_pkg::CMD_QUERY, 0, 0, 0, 0, 48'd6));
		for (int i = 0; i < NSLOT - 1; i++)
			send(mk(dtt_pkg::CMD_ADD, 0, (i < 3) ? 32'd0 : 32'(i * 7), 1'(i), 0, 48'd100));
		send(mk(dtt_pkg::CMD_ADD, 0, 32'hFFFF_FFFF, 1, 0, dtt_pkg::TIME_MAX - 10));
		send(mk(dtt_pkg::CMD_ADD, 0, 32'd5, 0, 0, 48'd100));
		send(mk(dtt_pkg::CMD_QUERY, 0, 0, 0, 0, 48'd101));
		send(mk(dtt_pkg::CMD_CANCEL, 3, 0, 0, 0, 48'd102));
		send(mk(dtt_pkg::CMD_CANCEL, 3, 0, 0, 0, 48'd103));
		send(mk(dtt_pkg::CMD_RESET, 3, 32'd77, 0, 1, 48'd104));
		send(mk(dtt_pkg::CMD_REFRESH, 5, 0, 0, 0, 48'd200));
		send(mk(dtt_pkg::CMD_RESET, 4, 32'd28, 0, 0, 48'd201));
		send(mk(dtt_pkg::CMD_RESET, 6, 32'd50, 0, 1, 48'd202));
		send(mk(dtt_pkg::CMD_RESET, 7, 32'd9, 0, 0, 48'd203));
		send(mk(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 48'd1000));
		send(mk(3'd6, 0, 0, 0, 0, 48'd1001));
		send(mk(3'd7, 15, 32'hFFFF_FFFF, 1, 1, dtt_pkg::TIME_MAX));
		send(mk(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, dtt_pkg::TIME_MAX));
		send(mk(dtt_pkg::CMD_EXPIRE, 0, 0, 0, 0, 48'd10));
		drain();

		windows[0] = 32'd0;
		windows[1] = 32'hFFFF_FFFF;
		windows[2] = $urandom_range(1, 10000);
		windows[3] = dtt_pkg::WINDOW_RESET;
		tnow = 48'd20;
		for (int ph = 0; ph < 4; ph++) begin
			write_window(windows[ph]);
			for (int n = 0; n < 98; n++)
				send(rand_request());
			drain();
		end

		if (errors == 0) begin
			$display("[deadline_timer_table] OK");
		end else begin
			$display("[deadline_timer_table] ERROR");
		end
		$finish;
	end

endmodule
